// ===== hdl/xrfc_pkg.sv =====
package xrfc_pkg;

    // Command codes carried by each input item.
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_BASE  = 2'd1,
        CMD_SEAL  = 2'd2,
        CMD_SUB   = 2'd3
    } t_cmd;

    localparam int unsigned HASH_W    = 32;
    localparam int unsigned PEND_W    = 24;
    localparam int unsigned ROT_AMT   = 3;
    localparam logic [HASH_W-1:0] SEAL_CONST = 32'h03F1_379E;

    // One input item as held in the input register.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       file_end;
    } t_item;

    // Result of one item, as handed from the hash unit to the output register.
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] file_hash;
        logic [HASH_W-1:0] combined_hash;
    } t_result;

    // Fixed left rotation by three bits.
    function automatic logic [HASH_W-1:0] rotl3(input logic [HASH_W-1:0] x);
        return {x[HASH_W-ROT_AMT-1:0], x[HASH_W-1:HASH_W-ROT_AMT]};
    endfunction

    // Fold the zero to three leftover bytes of a file into its hash, one byte at a time.
    function automatic logic [HASH_W-1:0] fold_tail(
        input logic [HASH_W-1:0] acc,
        input logic [PEND_W-1:0] pend,
        input logic [1:0]        cnt
    );
        logic [HASH_W-1:0] h;
        h = acc;
        for (int k = 0; k < 3; k++) begin
            if (k < int'(cnt)) begin
                h = rotl3(h ^ {24'd0, pend[8*k +: 8]});
            end
        end
        return h;
    endfunction

endpackage

// ===== hdl/xrfc_hash.sv =====
module xrfc_hash (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  xrfc_pkg::t_item  i_item,
    output xrfc_pkg::t_result o_res
);
    import xrfc_pkg::*;

    logic [HASH_W-1:0] r_file_acc;
    logic [PEND_W-1:0] r_pend_bytes;
    logic [1:0]        r_pend_count;
    logic [HASH_W-1:0] r_combined_acc;

    logic [HASH_W-1:0] n_file_acc;
    logic [PEND_W-1:0] n_pend_bytes;
    logic [1:0]        n_pend_count;
    logic [HASH_W-1:0] n_combined_acc;

    // Next state and result for the item in the input register.
    always_comb begin
        logic [HASH_W-1:0] w_acc;
        logic [PEND_W-1:0] w_pend;
        logic [1:0]        w_cnt;
        logic [HASH_W-1:0] w_hash;

        n_file_acc     = r_file_acc;
        n_pend_bytes   = r_pend_bytes;
        n_pend_count   = r_pend_count;
        n_combined_acc = r_combined_acc;
        o_res          = '0;
        w_acc          = r_file_acc;
        w_pend         = r_pend_bytes;
        w_cnt          = r_pend_count;
        w_hash         = '0;

        case (i_item.cmd)
            CMD_CLEAR: begin
                n_file_acc     = '0;
                n_pend_bytes   = '0;
                n_pend_count   = '0;
                n_combined_acc = '0;
            end
            CMD_SEAL: begin
                n_combined_acc      = rotl3(rotl3(r_combined_acc) ^ SEAL_CONST);
                o_res.valid         = 1'b1;
                o_res.file_hash     = '0;
                o_res.combined_hash = n_combined_acc;
            end
            CMD_BASE, CMD_SUB: begin
                // A fourth byte completes a little-endian word; otherwise the byte is held.
                if (r_pend_count == 2'd3) begin
                    w_acc  = rotl3(r_file_acc ^ {i_item.data_byte, r_pend_bytes});
                    w_pend = '0;
                    w_cnt  = '0;
                end else begin
                    w_pend[{r_pend_count, 3'b000} +: 8] = i_item.data_byte;
                    w_cnt  = r_pend_count + 2'd1;
                end
                n_file_acc   = w_acc;
                n_pend_bytes = w_pend;
                n_pend_count = w_cnt;

                // The last byte closes the file and merges its hash into the checksum.
                if (i_item.file_end) begin
                    w_hash = fold_tail(w_acc, w_pend, w_cnt);
                    if (i_item.cmd == CMD_BASE) begin
                        n_combined_acc = r_combined_acc ^ w_hash;
                    end else begin
                        n_combined_acc = rotl3(r_combined_acc ^ w_hash);
                    end
                    n_file_acc          = '0;
                    n_pend_bytes        = '0;
                    n_pend_count        = '0;
                    o_res.valid         = 1'b1;
                    o_res.file_hash     = w_hash;
                    o_res.combined_hash = n_combined_acc;
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    // Hash state advances only when the item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_acc     <= '0;
            r_pend_bytes   <= '0;
            r_pend_count   <= '0;
            r_combined_acc <= '0;
        end else if (i_en) begin
            r_file_acc     <= n_file_acc;
            r_pend_bytes   <= n_pend_bytes;
            r_pend_count   <= n_pend_count;
            r_combined_acc <= n_combined_acc;
        end
    end

endmodule

// ===== hdl/xor_rotate_file_checksum_core.sv =====
// XOR-rotate file checksum. Each input item is one command: clear, a byte of a base
// file, seal, or a byte of a subfile; file_end marks a file's last byte. Items that end
// a file, and seals, return one result (the file's hash and the combined checksum; a
// seal returns a file hash of zero); other items return none. One item is taken every
// clock cycle when the output side is not stalled. An item goes from the input register
// through the hash unit into the output register, which drives its result onto the
// output. The rate is set by the update of the running file and combined hash registers
// in the hash unit.
module xor_rotate_file_checksum_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_file_hash,
    output logic [31:0] o_combined_hash
);
    import xrfc_pkg::*;

    logic              r_in_valid;
    t_item             r_in_item;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_file_hash;
    logic [HASH_W-1:0] r_out_combined_hash;

    t_result           s_res;
    logic              s_out_free;
    logic              s_adv;
    logic              s_in_take;

    // Flow control: an item without a result may always move on; one with a result
    // needs the output register to be free.
    assign s_out_free = !r_out_valid || !i_stall;
    assign s_adv      = r_in_valid && (s_out_free || !s_res.valid);
    assign o_stall    = r_in_valid && !s_adv;
    assign s_in_take  = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || s_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_item.cmd       <= t_cmd'(i_command);
            r_in_item.data_byte <= i_data_byte;
            r_in_item.file_end  <= i_file_end;
        end
    end

    xrfc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_adv),
        .i_item  (r_in_item),
        .o_res   (s_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_adv && s_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free && s_adv && s_res.valid) begin
            r_out_file_hash     <= s_res.file_hash;
            r_out_combined_hash <= s_res.combined_hash;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_file_hash     = r_out_file_hash;
    assign o_combined_hash = r_out_combined_hash;

    // A seal leaving the input register shows up next cycle with a zero file hash.
    a_seal_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && r_in_item.cmd == CMD_SEAL) |=> (o_valid && o_file_hash == '0))
        else $error("seal item did not produce a zero file hash result");

    // A result never overwrites one that is still held by a stalled output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(s_adv && s_res.valid))
        else $error("result advanced into a stalled output register");

    // An empty input register never stalls the input side.
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with empty input register");

    // A clear item never produces a result.
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_item.cmd == CMD_CLEAR) |-> !s_res.valid)
        else $error("clear item produced a result");

endmodule

// ===== tb/sv/tb_xor_rotate_file_checksum_core.sv =====
module tb_xor_rotate_file_checksum_core;
    timeunit 1ns;
    timeprecision 1ps;

    import xrfc_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    // One command item waiting to be sent; hold_off makes the sender wait until
    // every outstanding result has come back before presenting it.
    typedef struct {
        t_cmd       cmd;
        logic [7:0] data;
        logic       last;
        bit         hold_off;
    } t_cmd_entry;

    // The pair of checksums that one result item carries.
    typedef struct packed {
        logic [31:0] file_hash;
        logic [31:0] combined_hash;
    } t_sums;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_CLEAR;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_file_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_file_hash;
    logic [31:0] o_combined_hash;

    t_cmd_entry  cmd_q[$];
    t_sums       checksum_q[$];

    // Running state of the checksum as the block should hold it.
    logic [31:0] word_acc;
    logic [23:0] tail_bytes;
    logic [1:0]  tail_cnt;
    logic [31:0] archive_acc;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned queued_total;
    bit          hold_next;
    bit          item_taken;
    bit          had_error;
    int          cycle_cnt;

    xor_rotate_file_checksum_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_data_byte    (i_data_byte),
        .i_file_end     (i_file_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_file_hash    (o_file_hash),
        .o_combined_hash(o_combined_hash)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rot3_left(input logic [31:0] x);
        return (x << 3) | (x >> 29);
    endfunction

    // Apply one accepted item to the expected state and queue its result, if any.
    function automatic void fold_item(input t_cmd c, input logic [7:0] b, input logic e);
        t_sums       s;
        logic [31:0] h;
        case (c)
            CMD_CLEAR: begin
                word_acc    = '0;
                tail_bytes  = '0;
                tail_cnt    = '0;
                archive_acc = '0;
            end
            CMD_SEAL: begin
                archive_acc     = rot3_left(rot3_left(archive_acc) ^ SEAL_CONST);
                s.file_hash     = '0;
                s.combined_hash = archive_acc;
                checksum_q      = {checksum_q, s};
            end
            default: begin
                // A fourth byte completes a little-endian word.
                if (tail_cnt == 2'd3) begin
                    word_acc   = rot3_left(word_acc ^ {b, tail_bytes});
                    tail_bytes = '0;
                    tail_cnt   = '0;
                end else begin
                    tail_bytes[8*tail_cnt +: 8] = b;
                    tail_cnt = tail_cnt + 2'd1;
                end
                if (e) begin
                    // Leftover bytes are folded in one at a time.
                    h = word_acc;
                    for (int k = 0; k < 3; k++) begin
                        if (k < tail_cnt) begin
                            h = rot3_left(h ^ {24'd0, tail_bytes[8*k +: 8]});
                        end
                    end
                    // Only the command of the last byte decides how the file is combined.
                    if (c == CMD_BASE) begin
                        archive_acc = archive_acc ^ h;
                    end else begin
                        archive_acc = rot3_left(archive_acc ^ h);
                    end
                    word_acc        = '0;
                    tail_bytes      = '0;
                    tail_cnt        = '0;
                    s.file_hash     = h;
                    s.combined_hash = archive_acc;
                    checksum_q      = {checksum_q, s};
                end
            end
        endcase
    endfunction

    function automatic void push_cmd(input t_cmd c, input logic [7:0] b, input logic e);
        t_cmd_entry ent;
        ent.cmd      = c;
        ent.data     = b;
        ent.last     = e;
        ent.hold_off = hold_next;
        hold_next    = 1'b0;
        cmd_q        = {cmd_q, ent};
        queued_total++;
    endfunction

    // Mostly whole files of random length and content, with seals, clears and
    // stray commands mixed in. One item in the middle waits for a full drain.
    task automatic add_random_traffic(input int unsigned n);
        int unsigned start;
        int unsigned len;
        int unsigned pick;
        bit          paused;
        t_cmd        fcmd;
        t_cmd        ocmd;
        start  = queued_total;
        paused = 1'b0;
        while (queued_total - start < n) begin
            if (!paused && queued_total - start >= n / 2) begin
                hold_next = 1'b1;
                paused    = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                push_cmd(CMD_CLEAR, 8'($urandom), 1'($urandom));
            end else if (pick < 13) begin
                push_cmd(CMD_SEAL, 8'($urandom), 1'($urandom));
            end else if (pick < 20) begin
                push_cmd(t_cmd'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end else begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 9);
                fcmd = ($urandom_range(0, 1) == 0) ? CMD_BASE : CMD_SUB;
                ocmd = (fcmd == CMD_BASE) ? CMD_SUB : CMD_BASE;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 49) == 0) begin
                        push_cmd(CMD_SEAL, 8'($urandom), 1'($urandom));
                    end
                    push_cmd(($urandom_range(0, 9) == 0) ? ocmd : fcmd, 8'($urandom),
                             i == len - 1);
                end
            end
        end
    endtask

    task automatic wait_for_drain();
        while (cmd_q.size() != 0 || i_valid || checksum_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: presents a new item once the previous one has been taken.
    always @(negedge i_clk) begin
        t_cmd_entry nxt;
        if (i_rst_n && (!i_valid || item_taken)) begin
            item_taken = 1'b0;
            if (cmd_q.size() != 0 && !(cmd_q[0].hold_off && checksum_q.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = cmd_q.pop_front();
                i_valid     <= 1'b1;
                i_command   <= nxt.cmd;
                i_data_byte <= nxt.data;
                i_file_end  <= nxt.last;
            end else begin
                i_valid     <= 1'b0;
                i_command   <= 2'($urandom);
                i_data_byte <= 8'($urandom);
                i_file_end  <= 1'($urandom);
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watches both channels: predicts on every accepted item and checks every result.
    always @(posedge i_clk) begin
        t_sums want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, checksum_q.size());
            $display("[xor_rotate_file_checksum_core] ERROR");
            $finish;
        end else begin
            if (i_rst_n && i_valid && !o_stall) begin
                fold_item(t_cmd'(i_command), i_data_byte, i_file_end);
                item_taken = 1'b1;
            end
            if (i_rst_n && o_valid && !i_stall) begin
                if (checksum_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h / %h",
                             $time, o_file_hash, o_combined_hash);
                    had_error = 1'b1;
                end else begin
                    want = checksum_q.pop_front();
                    if (o_file_hash !== want.file_hash) begin
                        $display("%0t: file_hash expected %h, got %h",
                                 $time, want.file_hash, o_file_hash);
                        had_error = 1'b1;
                    end
                    if (o_combined_hash !== want.combined_hash) begin
                        $display("%0t: combined_hash expected %h, got %h",
                                 $time, want.combined_hash, o_combined_hash);
                        had_error = 1'b1;
                    end
                end
            end
        end
    end

    initial begin
        word_acc      = '0;
        tail_bytes    = '0;
        tail_cnt      = '0;
        archive_acc   = '0;
        queued_total  = 0;
        hold_next     = 1'b0;
        item_taken    = 1'b0;
        had_error     = 1'b0;
        cycle_cnt     = 0;
        send_idle_pct = 35;
        recv_idle_pct = 82;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Clear with ignored fields set, then base files of one to four bytes.
        push_cmd(CMD_CLEAR, 8'hFF, 1'b1);
        push_cmd(CMD_BASE, 8'hFF, 1'b1);
        push_cmd(CMD_BASE, 8'h00, 1'b0);
        push_cmd(CMD_BASE, 8'hFF, 1'b1);
        push_cmd(CMD_BASE, 8'h80, 1'b0);
        push_cmd(CMD_BASE, 8'h01, 1'b0);
        push_cmd(CMD_BASE, 8'hFE, 1'b1);
        for (int i = 0; i < 4; i++) begin
            push_cmd(CMD_BASE, 8'hFF, i == 3);
        end
        push_cmd(CMD_SEAL, 8'hAA, 1'b0);
        // A five-byte subfile: one whole word plus a leftover byte.
        for (int i = 1; i <= 5; i++) begin
            push_cmd(CMD_SUB, 8'(i), i == 5);
        end
        // A seal in the middle of a file, and a file whose last byte switches command.
        push_cmd(CMD_BASE, 8'h12, 1'b0);
        push_cmd(CMD_SEAL, 8'h55, 1'b1);
        push_cmd(CMD_SUB, 8'h34, 1'b1);
        // A clear that drops a file in progress.
        push_cmd(CMD_BASE, 8'h77, 1'b0);
        push_cmd(CMD_CLEAR, 8'h5A, 1'b0);
        push_cmd(CMD_SUB, 8'h00, 1'b1);
        push_cmd(CMD_SEAL, 8'h00, 1'b1);

        add_random_traffic(410);
        wait_for_drain();

        send_idle_pct = 82;
        recv_idle_pct = 35;
        add_random_traffic(410);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_traffic(410);
        wait_for_drain();

        repeat (8) @(posedge i_clk);
        if (checksum_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, checksum_q.size());
        end
        if (!had_error && checksum_q.size() == 0) begin
            $display("[xor_rotate_file_checksum_core] OK");
        end else begin
            $display("[xor_rotate_file_checksum_core] ERROR");
        end
        $finish;
    end

endmodule
